/* rtl/assert_macros.svh */
// Assertion macros shared by the contour segment RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mscs_pkg.sv */
// Package for the marching squares contour segment core: register indexes,
// reset values, size defaults and the fixed case tables. Depends on nothing.
package mscs_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int COORD_W     = 15;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD  = 2'd3;

   // Register reset values.
   localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd4096;
   localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd4096;
   localparam logic [2:0]  RST_BYTES_PER_PIXEL = 3'd1;
   localparam logic [7:0]  RST_DARK_THRESHOLD  = 8'd128;

   // Cell edges.
   localparam logic [1:0] EDGE_TOP    = 2'd0;
   localparam logic [1:0] EDGE_RIGHT  = 2'd1;
   localparam logic [1:0] EDGE_BOTTOM = 2'd2;
   localparam logic [1:0] EDGE_LEFT   = 2'd3;

   // Number of segments for a case code; the saddles give two.
   function automatic logic [1:0] seg_count(input logic [3:0] code);
      logic [1:0] cnt;
      unique case (code)
         4'd0, 4'd15: cnt = 2'd0;
         4'd5, 4'd10: cnt = 2'd2;
         default:     cnt = 2'd1;
      endcase
      return cnt;
   endfunction

   // Start and end edge {start, end} of segment k of a case code.
   function automatic logic [3:0] seg_edges(input logic [3:0] code, input logic k);
      logic [3:0] e;
      unique case (code)
         4'd1:    e = {EDGE_TOP,    EDGE_LEFT};
         4'd2:    e = {EDGE_RIGHT,  EDGE_TOP};
         4'd3:    e = {EDGE_RIGHT,  EDGE_LEFT};
         4'd4:    e = {EDGE_BOTTOM, EDGE_RIGHT};
         4'd5:    e = k ? {EDGE_BOTTOM, EDGE_RIGHT} : {EDGE_TOP, EDGE_LEFT};
         4'd6:    e = {EDGE_BOTTOM, EDGE_TOP};
         4'd7:    e = {EDGE_BOTTOM, EDGE_LEFT};
         4'd8:    e = {EDGE_LEFT,   EDGE_BOTTOM};
         4'd9:    e = {EDGE_TOP,    EDGE_BOTTOM};
         4'd10:   e = k ? {EDGE_LEFT, EDGE_BOTTOM} : {EDGE_RIGHT, EDGE_TOP};
         4'd11:   e = {EDGE_RIGHT,  EDGE_BOTTOM};
         4'd12:   e = {EDGE_LEFT,   EDGE_RIGHT};
         4'd13:   e = {EDGE_TOP,    EDGE_RIGHT};
         4'd14:   e = {EDGE_LEFT,   EDGE_TOP};
         default: e = {EDGE_TOP,    EDGE_TOP};
      endcase
      return e;
   endfunction

   // Half-pixel offsets of an edge midpoint within its cell.
   function automatic logic [1:0] edge_dx(input logic [1:0] e);
      logic [1:0] d;
      unique case (e)
         EDGE_TOP:    d = 2'd1;
         EDGE_RIGHT:  d = 2'd2;
         EDGE_BOTTOM: d = 2'd1;
         default:     d = 2'd0;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] edge_dy(input logic [1:0] e);
      logic [1:0] d;
      unique case (e)
         EDGE_TOP:    d = 2'd0;
         EDGE_RIGHT:  d = 2'd1;
         EDGE_BOTTOM: d = 2'd2;
         default:     d = 2'd1;
      endcase
      return d;
   endfunction

endpackage

/* rtl/marching_squares_contour_segments_core.sv */
// Marching squares contour segment core: line buffer memory, cell former and
// segment sequencer. Depends on mscs_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Image bytes arrive one per transaction in raster order with bytes_per_pixel
// interleaved channels; the first byte of each pixel decides whether the pixel
// is solid (below dark_threshold). The core keeps the solid bits of the row
// above in a single-port style line buffer of MAX_WIDTH one-bit entries that is
// read and written once per pixel at the same clock edge, so consecutive pixels
// never collide in it. Each pixel completes up to four 2x2 cells of the grid
// padded with non-solid pixels, and each cell gives zero, one or two segments
// with end points in half-pixel units; bottom-row border cells come out
// interleaved with the pixels that finish them. Rate: one byte per cycle is
// taken while the output is not stalled and each pixel produces at most one
// segment; a pixel with more segments holds the segment sequencer until all
// are sent, as the output register takes one segment per cycle unless stalled.
// The line buffer is not cleared after reset: first-row reads are masked off,
// and every later read hits an entry written in an earlier row. Configuration
// registers must be written only while no transaction is in flight.
module marching_squares_contour_segments_core #(
   parameter int MAX_WIDTH  = mscs_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mscs_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration port.
   input  logic                                  csr_write_enable,
   input  logic [mscs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mscs_pkg::CSR_DATA_W-1:0]       csr_write_data,
   // Input byte channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [7:0]                            req_pixel_byte,
   // Segment channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mscs_pkg::COORD_W-1:0]   rsp_seg_start_x,
   output logic signed [mscs_pkg::COORD_W-1:0]   rsp_seg_start_y,
   output logic signed [mscs_pkg::COORD_W-1:0]   rsp_seg_end_x,
   output logic signed [mscs_pkg::COORD_W-1:0]   rsp_seg_end_y,
   output logic                                  rsp_last_segment
);

   localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW    = mscs_pkg::COORD_W;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;
   logic [2:0]  bytes_per_pixel_ff;
   logic [7:0]  dark_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff     <= mscs_pkg::RST_IMAGE_WIDTH;
         image_height_ff    <= mscs_pkg::RST_IMAGE_HEIGHT;
         bytes_per_pixel_ff <= mscs_pkg::RST_BYTES_PER_PIXEL;
         dark_threshold_ff  <= mscs_pkg::RST_DARK_THRESHOLD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mscs_pkg::CSR_IMAGE_WIDTH:     image_width_ff     <= csr_write_data;
            mscs_pkg::CSR_IMAGE_HEIGHT:    image_height_ff    <= csr_write_data;
            mscs_pkg::CSR_BYTES_PER_PIXEL: bytes_per_pixel_ff <= csr_write_data[2:0];
            mscs_pkg::CSR_DARK_THRESHOLD:  dark_threshold_ff  <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Clamped sizes, held as "size minus one" so that they fit the counters.
   logic [COL_W-1:0] width_m1;
   logic [ROW_W-1:0] height_m1;
   logic [1:0]       bpp_m1;

   always_comb begin
      if (image_width_ff == 13'd0) begin
         width_m1 = '0;
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_m1 = COL_W'(32'(image_width_ff) - 32'd1);
      end
      if (image_height_ff == 13'd0) begin
         height_m1 = '0;
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         height_m1 = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_m1 = ROW_W'(32'(image_height_ff) - 32'd1);
      end
      if (bytes_per_pixel_ff == 3'd0) begin
         bpp_m1 = 2'd0;
      end else if (bytes_per_pixel_ff > 3'd4) begin
         bpp_m1 = 2'd3;
      end else begin
         bpp_m1 = 2'(bytes_per_pixel_ff - 3'd1);
      end
   end

   // ---------------------------------------------------------------------
   // Front stage: position tracking and line buffer access.
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] column_count_ff;
   logic [ROW_W-1:0] row_count_ff;
   logic [1:0]       channel_count_ff;

   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             last_col;
   logic             last_row;
   logic             cur_solid;
   logic             req_accept;
   logic             pixel_accept;

   assign col          = (column_count_ff > width_m1) ? width_m1 : column_count_ff;
   assign row          = (row_count_ff > height_m1) ? height_m1 : row_count_ff;
   assign last_col     = (col == width_m1);
   assign last_row     = (row == height_m1);
   assign cur_solid    = (req_pixel_byte < dark_threshold_ff);
   assign req_accept   = req_valid && req_ready;
   assign pixel_accept = req_accept && (channel_count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         channel_count_ff <= 2'd0;
      end else if (req_accept) begin
         channel_count_ff <= (channel_count_ff >= bpp_m1) ? 2'd0 : channel_count_ff + 2'd1;
         if (pixel_accept) begin
            if (last_col) begin
               column_count_ff <= '0;
               row_count_ff    <= last_row ? '0 : ROW_W'(row + 1'b1);
            end else begin
               column_count_ff <= COL_W'(col + 1'b1);
               row_count_ff    <= row;
            end
         end
      end
   end

   // Line buffer of solid bits: the read returns the row above, the write
   // stores this pixel for the row below, both at the pixel's own column.
   logic line_buf [MAX_WIDTH];
   logic above_rd_ff;

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         above_rd_ff   <= line_buf[col];
         line_buf[col] <= cur_solid;
      end
   end

   // ---------------------------------------------------------------------
   // Cell stage: one pixel held while its segments are sent out.
   // ---------------------------------------------------------------------
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_cur_ff;
   logic             s1_last_col_ff;
   logic             s1_last_row_ff;
   logic             s1_row0_ff;
   logic [7:0]       done_ff;
   logic             left_bit_ff;
   logic             upper_left_ff;

   logic             above;
   logic [3:0]       cell_code [4];
   logic [3:0]       cell_en;
   logic [CW-1:0]    cell_x [4];
   logic [CW-1:0]    cell_y [4];
   logic [7:0]       slot_en;
   logic [7:0]       pending;
   logic [2:0]       pick;
   logic [7:0]       pick_mask;
   logic             pick_last;
   logic             out_free;
   logic             push;
   logic             s1_finish;

   assign above = s1_row0_ff ? 1'b0 : above_rd_ff;

   always_comb begin
      logic [CW-1:0] x_hi;
      logic [CW-1:0] y_hi;
      logic [1:0]    cnt;
      x_hi = CW'(32'(s1_col_ff) << 1);
      y_hi = CW'(32'(s1_row_ff) << 1);
      // Corner weights: top-left 1, top-right 2, bottom-right 4, bottom-left 8.
      cell_code[0] = {left_bit_ff, s1_cur_ff, above, upper_left_ff};
      cell_code[1] = {s1_cur_ff, 1'b0, 1'b0, above};
      cell_code[2] = {1'b0, 1'b0, s1_cur_ff, left_bit_ff};
      cell_code[3] = {1'b0, 1'b0, 1'b0, s1_cur_ff};
      cell_en = {s1_last_col_ff && s1_last_row_ff, s1_last_row_ff, s1_last_col_ff, 1'b1};
      cell_x[0] = x_hi - CW'(2);
      cell_x[1] = x_hi;
      cell_x[2] = x_hi - CW'(2);
      cell_x[3] = x_hi;
      cell_y[0] = y_hi - CW'(2);
      cell_y[1] = y_hi - CW'(2);
      cell_y[2] = y_hi;
      cell_y[3] = y_hi;
      for (int i = 0; i < 4; i++) begin
         cnt              = mscs_pkg::seg_count(cell_code[i]);
         slot_en[2*i]     = cell_en[i] && (cnt != 2'd0);
         slot_en[2*i + 1] = cell_en[i] && (cnt == 2'd2);
      end
   end

   assign pending = s1_valid_ff ? (slot_en & ~done_ff) : 8'd0;

   // Lowest pending slot goes next; slots run in cell order, then segment.
   always_comb begin
      pick = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (pending[i]) begin
            pick = 3'(i);
         end
      end
   end

   assign pick_mask = 8'd1 << pick;
   assign pick_last = ((pending & ~pick_mask) == 8'd0);
   assign out_free  = !rsp_valid || rsp_ready;
   assign push      = s1_valid_ff && (pending != 8'd0) && out_free;
   assign s1_finish = s1_valid_ff && ((pending == 8'd0) || (push && pick_last));
   assign req_ready = !s1_valid_ff || s1_finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         done_ff       <= 8'd0;
         left_bit_ff   <= 1'b0;
         upper_left_ff <= 1'b0;
      end else begin
         if (s1_finish) begin
            left_bit_ff   <= s1_last_col_ff ? 1'b0 : s1_cur_ff;
            upper_left_ff <= s1_last_col_ff ? 1'b0 : above;
         end
         if (pixel_accept) begin
            s1_valid_ff <= 1'b1;
            done_ff     <= 8'd0;
         end else if (s1_finish) begin
            s1_valid_ff <= 1'b0;
         end else if (push) begin
            done_ff <= done_ff | pick_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         s1_col_ff      <= col;
         s1_row_ff      <= row;
         s1_cur_ff      <= cur_solid;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_row0_ff     <= (row == '0);
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic          rsp_valid_ff;
   logic [CW-1:0] start_x_in;
   logic [CW-1:0] start_y_in;
   logic [CW-1:0] end_x_in;
   logic [CW-1:0] end_y_in;
   logic signed [CW-1:0] start_x_ff;
   logic signed [CW-1:0] start_y_ff;
   logic signed [CW-1:0] end_x_ff;
   logic signed [CW-1:0] end_y_ff;
   logic          last_ff;

   always_comb begin
      logic [1:0] cell_sel;
      logic [3:0] edges;
      cell_sel   = pick[2:1];
      edges      = mscs_pkg::seg_edges(cell_code[cell_sel], pick[0]);
      start_x_in = cell_x[cell_sel] + CW'(mscs_pkg::edge_dx(edges[3:2]));
      start_y_in = cell_y[cell_sel] + CW'(mscs_pkg::edge_dy(edges[3:2]));
      end_x_in   = cell_x[cell_sel] + CW'(mscs_pkg::edge_dx(edges[1:0]));
      end_y_in   = cell_y[cell_sel] + CW'(mscs_pkg::edge_dy(edges[1:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         start_x_ff <= $signed(start_x_in);
         start_y_ff <= $signed(start_y_in);
         end_x_ff   <= $signed(end_x_in);
         end_y_ff   <= $signed(end_y_in);
         last_ff    <= pick_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seg_start_x  = start_x_ff;
   assign rsp_seg_start_y  = start_y_ff;
   assign rsp_seg_end_x    = end_x_ff;
   assign rsp_seg_end_y    = end_y_ff;
   assign rsp_last_segment = last_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `MSCS_ASSERT_IMPLIES(a_done_within_enabled, clock, reset, s1_valid_ff, ((done_ff & ~slot_en) == 8'd0), "sequencer marked a slot that the cell does not produce")
   `MSCS_ASSERT_NEXT(a_stall_holds_sequencer, clock, reset, s1_valid_ff && !out_free && (pending != 8'd0), $stable(done_ff) && s1_valid_ff, "sequencer advanced while the output register was full")
   `MSCS_ASSERT_IMPLIES(a_push_single_slot, clock, reset, push, $onehot(pick_mask & pending), "pushed segment is not a pending slot")

endmodule
